FILE: sv/lcs_pkg.sv
`timescale 1ns / 1ps

package lcs_pkg;

   localparam int LAMP_COUNT_DEF = 31;

   localparam int ID_W        = 16;
   localparam int CHAN_W      = 8;
   localparam int LED_INDEX_W = 5;
   localparam int COLOR_W     = 3 * CHAN_W;

   localparam int ACTION_W = 2;
   typedef enum logic [ACTION_W-1:0] {
      ACT_SET_LAMP  = 2'd0,
      ACT_SET_RANGE = 2'd1,
      ACT_APPLY     = 2'd2,
      ACT_CONTROL   = 2'd3
   } action_type;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_LIGHT_LIMIT  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LAMPS_ENABLE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DARKER_GAP   = 2'd2;

   localparam logic [CHAN_W-1:0] LIGHT_LIMIT_RST  = 8'd255;
   localparam logic              LAMPS_ENABLE_RST = 1'b1;
   localparam logic              DARKER_GAP_RST   = 1'b0;

   // request beat layout
   localparam int REQ_DATA_W     = 72;
   localparam int REQ_LAMP_ID_LO = 0;
   localparam int REQ_RANGE_LO   = 16;
   localparam int REQ_RED_LO     = 32;
   localparam int REQ_GREEN_LO   = 40;
   localparam int REQ_BLUE_LO    = 48;
   localparam int REQ_INTEN_LO   = 56;
   localparam int REQ_APPLY_BIT  = 64;
   localparam int REQ_AUTO_BIT   = 65;
   localparam int REQ_LINK_BIT   = 66;

   // response beat layout
   localparam int RSP_DATA_W   = 32;
   localparam int RSP_USED_W   = LED_INDEX_W + COLOR_W;

   typedef struct packed {
      logic load_item;
      logic decode;
      logic fill_write;
      logic set_auto;
      logic apply_start;
      logic apply_run;
      logic clear_dirty;
   } cmd_type;

   typedef struct packed {
      action_type action;
      logic       autonomous;
      logic       apply_ok;
      logic       dirty;
      logic       apply_after;
      logic       fill_last;
      logic       apply_done;
   } status_type;

   // floor(x / 255), exact for any x up to 255 * 255 (any product of two 8-bit values)
   function automatic logic [CHAN_W-1:0] div255(input logic [2*CHAN_W-1:0] x);
      logic [2*CHAN_W:0] t;
      t = (2*CHAN_W+1)'(x) + (2*CHAN_W+1)'(x[2*CHAN_W-1:CHAN_W]) + (2*CHAN_W+1)'(1);
      return t[2*CHAN_W-1:CHAN_W];
   endfunction

endpackage

FILE: sv/lcs_ram.sv
`timescale 1ns / 1ps

module lcs_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 31
) (
   input  logic                             clock,
   input  logic                             we,
   input  logic [$clog2(DEPTH)-1:0]         waddr,
   input  logic [WIDTH-1:0]                 wdata,
   input  logic                             re,
   input  logic [$clog2(DEPTH)-1:0]         raddr,
   output logic [WIDTH-1:0]                 rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: sv/lcs_ctrl.sv
`timescale 1ns / 1ps

module lcs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  lcs_pkg::status_type status,
   output lcs_pkg::cmd_type    cmd
);
   import lcs_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_FILL,
      ST_APPLY
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.decode = 1'b1;
            case (status.action)
               ACT_SET_LAMP, ACT_SET_RANGE: begin
                  state_in = status.autonomous ? ST_IDLE : ST_FILL;
               end
               ACT_APPLY: begin
                  if (status.apply_ok && status.dirty) begin
                     cmd.apply_start = 1'b1;
                     state_in        = ST_APPLY;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
               default: begin
                  cmd.set_auto = 1'b1;
                  state_in     = ST_IDLE;
               end
            endcase
         end
         ST_FILL: begin
            cmd.fill_write = 1'b1;
            if (status.fill_last) begin
               if ((status.action == ACT_SET_RANGE || status.apply_after)
                   && status.apply_ok) begin
                  cmd.apply_start = 1'b1;
                  state_in        = ST_APPLY;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_APPLY: begin
            cmd.apply_run = 1'b1;
            if (status.apply_done) begin
               cmd.clear_dirty = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

endmodule

FILE: sv/lcs_datapath.sv
`timescale 1ns / 1ps

module lcs_datapath #(
   parameter int LAMP_COUNT = lcs_pkg::LAMP_COUNT_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [lcs_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [lcs_pkg::ACTION_W-1:0]       req_tuser,
   input  lcs_pkg::cmd_type                   cmd,
   output lcs_pkg::status_type                status,
   input  logic                               csr_we,
   input  logic [lcs_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lcs_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [lcs_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                               rsp_tlast
);
   import lcs_pkg::*;

   localparam int IDX_W = $clog2(LAMP_COUNT);
   localparam int CNT_W = $clog2(LAMP_COUNT + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LAMP_COUNT - 1);

   // item registers
   action_type        action_ff;
   logic [ID_W-1:0]   lamp_id_ff;
   logic [ID_W-1:0]   range_end_ff;
   logic [CHAN_W-1:0] red_ff, green_ff, blue_ff, inten_ff;
   logic              apply_after_ff, auto_req_ff, link_ff;

   // block state and configuration
   logic              dirty_ff, auto_mode_ff;
   logic [CHAN_W-1:0] light_limit_ff;
   logic              lamps_enable_ff, darker_gap_ff;
   logic [LAMP_COUNT-1:0] written_ff;

   // fill
   logic [COLOR_W-1:0] color_ff;
   logic [IDX_W-1:0]   wr_ptr_ff, hi_ff;
   logic [IDX_W-1:0]   lo_c, hi_c, lo_in, hi_in;

   // apply pipeline
   logic [CNT_W-1:0]   rd_ptr_ff;
   logic               s1_valid_ff, s1_written_ff;
   logic [IDX_W-1:0]   s1_lamp_ff;
   logic [COLOR_W-1:0] ram_rdata, stored;
   logic               advance, issue;
   logic [IDX_W-1:0]   rd_idx;

   logic                   rsp_valid_ff, rsp_last_ff;
   logic [LED_INDEX_W-1:0] rsp_led_ff, led_in;
   logic [COLOR_W-1:0]     rsp_color_ff, color_out_in, color_prod_in;
   logic [IDX_W-1:0]       led_diff;
   logic [IDX_W+LED_INDEX_W-1:0] led_ext;

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         action_ff      <= action_type'(req_tuser);
         lamp_id_ff     <= req_tdata[REQ_LAMP_ID_LO +: ID_W];
         range_end_ff   <= req_tdata[REQ_RANGE_LO +: ID_W];
         red_ff         <= req_tdata[REQ_RED_LO +: CHAN_W];
         green_ff       <= req_tdata[REQ_GREEN_LO +: CHAN_W];
         blue_ff        <= req_tdata[REQ_BLUE_LO +: CHAN_W];
         inten_ff       <= req_tdata[REQ_INTEN_LO +: CHAN_W];
         apply_after_ff <= req_tdata[REQ_APPLY_BIT];
         auto_req_ff    <= req_tdata[REQ_AUTO_BIT];
         link_ff        <= req_tdata[REQ_LINK_BIT];
      end
   end

   // clamp, swap; a single lamp uses lamp_id for both ends
   always_comb begin
      lo_c = (lamp_id_ff < ID_W'(LAMP_COUNT)) ? lamp_id_ff[IDX_W-1:0] : LAST_IDX;
      hi_c = (range_end_ff < ID_W'(LAMP_COUNT)) ? range_end_ff[IDX_W-1:0] : LAST_IDX;
      if (action_ff == ACT_SET_LAMP) begin
         lo_in = lo_c;
         hi_in = lo_c;
      end else if (hi_c < lo_c) begin
         lo_in = hi_c;
         hi_in = lo_c;
      end else begin
         lo_in = lo_c;
         hi_in = hi_c;
      end
      color_prod_in = {div255(16'(blue_ff) * 16'(inten_ff)),
                       div255(16'(green_ff) * 16'(inten_ff)),
                       div255(16'(red_ff) * 16'(inten_ff))};
   end

   always_ff @(posedge clock) begin
      if (cmd.decode) begin
         color_ff  <= color_prod_in;
         wr_ptr_ff <= lo_in;
         hi_ff     <= hi_in;
      end else if (cmd.fill_write) begin
         wr_ptr_ff <= wr_ptr_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dirty_ff        <= 1'b1;
         auto_mode_ff    <= 1'b0;
         written_ff      <= '0;
         light_limit_ff  <= LIGHT_LIMIT_RST;
         lamps_enable_ff <= LAMPS_ENABLE_RST;
         darker_gap_ff   <= DARKER_GAP_RST;
      end else begin
         if (cmd.fill_write) begin
            written_ff[wr_ptr_ff] <= 1'b1;
            dirty_ff              <= 1'b1;
         end else if (cmd.clear_dirty) begin
            dirty_ff <= 1'b0;
         end
         if (cmd.set_auto) begin
            auto_mode_ff <= auto_req_ff;
         end
         if (csr_we) begin
            case (csr_index)
               CSR_LIGHT_LIMIT:  light_limit_ff  <= csr_wdata;
               CSR_LAMPS_ENABLE: lamps_enable_ff <= csr_wdata[0];
               CSR_DARKER_GAP:   darker_gap_ff   <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   assign advance = !rsp_valid_ff || rsp_tready;
   assign issue   = cmd.apply_run && advance && (rd_ptr_ff < CNT_W'(LAMP_COUNT));
   assign rd_idx  = rd_ptr_ff[IDX_W-1:0];

   lcs_ram #(
      .WIDTH (COLOR_W),
      .DEPTH (LAMP_COUNT)
   ) u_store (
      .clock (clock),
      .we    (cmd.fill_write),
      .waddr (wr_ptr_ff),
      .wdata (color_ff),
      .re    (issue),
      .raddr (rd_idx),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff   <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (cmd.apply_start) begin
            rd_ptr_ff <= '0;
         end else if (issue) begin
            rd_ptr_ff <= rd_ptr_ff + CNT_W'(1);
         end
         if (advance) begin
            s1_valid_ff <= issue;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_lamp_ff    <= rd_idx;
         s1_written_ff <= written_ff[rd_idx];
      end
   end

   // unwritten lamps as black, limit scaling, gap dimming and LED index
   always_comb begin
      logic [CHAN_W-1:0] ch;
      stored = s1_written_ff ? ram_rdata : '0;
      for (int c = 0; c < 3; c++) begin
         ch = div255(16'(stored[c*CHAN_W +: CHAN_W]) * 16'(light_limit_ff));
         if (darker_gap_ff && s1_lamp_ff[0]) begin
            ch = ch >> 2;
         end
         color_out_in[c*CHAN_W +: CHAN_W] = ch;
      end
      led_diff = LAST_IDX - s1_lamp_ff;
      led_ext  = (IDX_W+LED_INDEX_W)'(led_diff);
      led_in   = led_ext[LED_INDEX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         rsp_led_ff   <= led_in;
         rsp_color_ff <= color_out_in;
         rsp_last_ff  <= (s1_lamp_ff == LAST_IDX);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {(RSP_DATA_W-RSP_USED_W)'(0), rsp_color_ff, rsp_led_ff};

   always_comb begin
      status             = '0;
      status.action      = action_ff;
      status.autonomous  = auto_mode_ff;
      status.apply_ok    = lamps_enable_ff && !link_ff;
      status.dirty       = dirty_ff;
      status.apply_after = apply_after_ff;
      status.fill_last   = (wr_ptr_ff == hi_ff);
      status.apply_done  = advance && s1_valid_ff && (s1_lamp_ff == LAST_IDX);
   end

   a_no_fill_in_apply: assert property (@(posedge clock) disable iff (reset)
      !(cmd.fill_write && cmd.apply_run))
      else $error("store write during frame readout");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_lamp_ff))
      else $error("read stage lost data on stall");

   a_done_last_beat: assert property (@(posedge clock) disable iff (reset)
      status.apply_done |=> rsp_valid_ff && rsp_last_ff)
      else $error("frame end not marked on output");

   a_fill_dirty: assert property (@(posedge clock) disable iff (reset)
      cmd.fill_write |=> dirty_ff)
      else $error("store write left store clean");

endmodule

FILE: sv/led_lamp_color_store.sv
`timescale 1ns / 1ps

// Lamp color store for a row of LAMP_COUNT lamps.
// req_*: one beat per command (tuser = action). Set lamp stores one scaled
//   color, set range fills a clamped span, apply emits a frame, control sets
//   autonomous mode. req_tready is high only while no command is in work.
// rsp_*: during apply one beat per lamp, lamp 0 first, tlast on the last lamp.
// csr_*: write-only registers (light limit, lamps enable, darker gap); the user must
//   write them only while the block is idle, the block itself does not enforce it.
// Command steps: accept, decode, then one store write per lamp of the span
//   (single store write port); apply reads the frame through the single store
//   read port, one lamp per cycle while the receiver takes beats.
// A frame's first beat passes decode (and the span fill after set lamp or
//   range), store read, output register; the rest one per cycle if not stalled.
// A stalled receiver freezes the readout pipeline; the output register keeps
//   its beat, and a new command is taken while the final beat waits.
// Reset: store reads as black, store marked dirty, autonomous mode off,
//   light limit 255, lamps enabled, darker gap off. No clearing pass.
module led_lamp_color_store #(
   parameter int LAMP_COUNT = lcs_pkg::LAMP_COUNT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // lamp_id[15:0], range_end[31:16], red[39:32], green[47:40], blue[55:48],
   // intensity[63:56], apply_after[64], autonomous[65], game_link_active[66]
   input  logic [lcs_pkg::REQ_DATA_W-1:0]   req_tdata,
   // action[1:0]
   input  logic [lcs_pkg::ACTION_W-1:0]     req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // led_index[4:0], out_red[12:5], out_green[20:13], out_blue[28:21]
   output logic [lcs_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                             rsp_tlast,
   input  logic                             csr_we,
   input  logic [lcs_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [lcs_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import lcs_pkg::*;

   cmd_type    cmd;
   status_type status;

   lcs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lcs_datapath #(
      .LAMP_COUNT (LAMP_COUNT)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .status     (status),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
